@@ rtl/core/paced_text_message_queue_top_macros.svh @@
// assertion macros for the paced text message queue
`ifndef PACED_TEXT_MESSAGE_QUEUE_TOP_MACROS_SVH
`define PACED_TEXT_MESSAGE_QUEUE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, disabled during reset
`define PTMQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ptmq: same-cycle check failed");
// next-cycle implication, disabled during reset
`define PTMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ptmq: next-cycle check failed");
`else
`define PTMQ_ASSERT_SAME(lbl, clk, rst_n, ante, cons)
`define PTMQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/core/ptmq_pkg.sv @@
`timescale 1ns / 1ps

package ptmq_pkg;

    localparam logic FUNC_TICK  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    localparam logic [7:0] CFG_TICK_PERIOD   = 8'd0;
    localparam logic [7:0] CFG_SINK_ATTACHED = 8'd1;

    localparam logic [7:0] TICK_PERIOD_RESET   = 8'd5;
    localparam logic       SINK_ATTACHED_RESET = 1'b1;

    typedef struct packed {
        logic       func;
        logic [7:0] text_char;
        logic       sink_ready;
    } t_item;

    typedef struct packed {
        logic [7:0] tick_period;
        logic       sink_attached;
    } t_cfg;

    typedef struct packed {
        logic       valid;
        logic [7:0] played_char;
        logic       message_end;
    } t_result;

endpackage

@@ rtl/core/paced_text_message_queue_top.sv @@
`timescale 1ns / 1ps

// channel   direction  signals
// in        sink       i_in_valid / o_in_ready, i_func, i_text_char, i_sink_ready
// out       source     o_out_valid / i_out_ready, o_played_char, o_message_end
// cfg       sink       i_cfg_valid / o_cfg_ready, i_cfg_index, i_cfg_data
//
// an accepted item is held in the input register and processed, once the
// output register is free, by one pass of the update logic; its result is then
// registered, and one item can follow every cycle while the output is free.
// the message store is a ram with registered reads, fetched ahead from the next
// queue state. reset is synchronous, active low, no clearing pass.
// a stalled output holds the item in the input register until the output frees.

`include "paced_text_message_queue_top_macros.svh"

module paced_text_message_queue_top #(
    parameter int QUEUE_SLOTS = 10,
    parameter int SLOT_BYTES  = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic       i_func,
    input  logic [7:0] i_text_char,
    input  logic       i_sink_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_played_char,
    output logic       o_message_end,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_index,
    input  logic [7:0] i_cfg_data
);

    ptmq_pkg::t_cfg    r_cfg;
    ptmq_pkg::t_item   r_in_item;
    logic              r_in_valid;
    logic              r_out_valid;
    logic [7:0]        r_played_char;
    logic              r_message_end;
    ptmq_pkg::t_result eng_res;
    logic              process;

    assign o_cfg_ready = 1'b1;
    assign process     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || process;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.tick_period   <= ptmq_pkg::TICK_PERIOD_RESET;
            r_cfg.sink_attached <= ptmq_pkg::SINK_ATTACHED_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                ptmq_pkg::CFG_TICK_PERIOD:   r_cfg.tick_period   <= i_cfg_data;
                ptmq_pkg::CFG_SINK_ATTACHED: r_cfg.sink_attached <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item.func       <= i_func;
            r_in_item.text_char  <= i_text_char;
            r_in_item.sink_ready <= i_sink_ready;
        end
    end

    ptmq_engine #(
        .QUEUE_SLOTS (QUEUE_SLOTS),
        .SLOT_BYTES  (SLOT_BYTES)
    ) u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (process),
        .i_item  (r_in_item),
        .i_cfg   (r_cfg),
        .o_res   (eng_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (process) begin
            r_out_valid <= eng_res.valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (process && eng_res.valid) begin
            r_played_char <= eng_res.played_char;
            r_message_end <= eng_res.message_end;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_played_char = r_played_char;
    assign o_message_end = r_message_end;

    // a played character is never the terminator
    `PTMQ_ASSERT_SAME(a_char_nonzero, i_clk, i_rst_n, o_out_valid, o_played_char != 8'd0)
    // only tick transactions produce output
    `PTMQ_ASSERT_SAME(a_result_from_tick, i_clk, i_rst_n, process && eng_res.valid, r_in_item.func == ptmq_pkg::FUNC_TICK)
    // a produced result is presented on the next cycle
    `PTMQ_ASSERT_NEXT(a_result_lands, i_clk, i_rst_n, process && eng_res.valid, r_out_valid)

endmodule

@@ rtl/core/ptmq_ram.sv @@
`timescale 1ns / 1ps

module ptmq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 160,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr_a,
    input  logic [AW-1:0]    i_raddr_b,
    output logic [WIDTH-1:0] o_rdata_a,
    output logic [WIDTH-1:0] o_rdata_b
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

@@ rtl/core/ptmq_engine.sv @@
`timescale 1ns / 1ps

module ptmq_engine #(
    parameter int QUEUE_SLOTS = 10,
    parameter int SLOT_BYTES  = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  ptmq_pkg::t_item   i_item,
    input  ptmq_pkg::t_cfg    i_cfg,
    output ptmq_pkg::t_result o_res
);

    localparam int SW    = $clog2(QUEUE_SLOTS);
    localparam int PW    = $clog2(SLOT_BYTES + 1);
    localparam int DEPTH = QUEUE_SLOTS * SLOT_BYTES;
    localparam int AW    = $clog2(DEPTH);

    logic [SW-1:0] r_read_slot,  n_read_slot;
    logic [SW-1:0] r_write_slot, n_write_slot;
    logic [PW-1:0] r_play_pos,   n_play_pos;
    logic [PW-1:0] r_fill_pos,   n_fill_pos;
    logic [7:0]    r_tick_phase, n_tick_phase;

    // read-port bookkeeping: bypass of a same-edge write, out-of-slot positions
    logic          r_fwd_a, r_fwd_b;
    logic [7:0]    r_fwd_data;
    logic          r_oob_a, r_oob_b;

    logic          we;
    logic [AW-1:0] waddr;
    logic [AW-1:0] raddr_a, raddr_b;
    logic          oob_a, oob_b;
    logic [7:0]    q_a, q_b;
    logic [7:0]    char_a, char_b;
    logic [PW:0]   next_pos_wide;
    logic [7:0]    period;
    logic [8:0]    phase_inc;
    logic          attempt;

    function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] s);
        logic [SW-1:0] r;
        r = (s == SW'(QUEUE_SLOTS - 1)) ? '0 : s + 1'b1;
        return r;
    endfunction

    function automatic logic [AW-1:0] slot_addr(input logic [SW-1:0] s,
                                                input logic [PW-1:0] p);
        logic [AW-1:0] a;
        a = AW'(AW'(s) * AW'(SLOT_BYTES)) + AW'(p);
        return a;
    endfunction

    assign char_a = r_oob_a ? 8'd0 : (r_fwd_a ? r_fwd_data : q_a);
    assign char_b = r_oob_b ? 8'd0 : (r_fwd_b ? r_fwd_data : q_b);

    assign period    = (i_cfg.tick_period == 8'd0) ? 8'd1 : i_cfg.tick_period;
    assign phase_inc = {1'b0, r_tick_phase} + 9'd1;
    assign attempt   = (r_tick_phase == 8'd0);
    assign waddr     = slot_addr(r_write_slot, r_fill_pos);

    always_comb begin
        n_read_slot  = r_read_slot;
        n_write_slot = r_write_slot;
        n_play_pos   = r_play_pos;
        n_fill_pos   = r_fill_pos;
        n_tick_phase = r_tick_phase;
        we           = 1'b0;
        o_res        = '0;
        if (i_step) begin
            if (i_item.func == ptmq_pkg::FUNC_WRITE) begin
                if (i_item.text_char != 8'd0) begin
                    // characters past the last usable position are dropped
                    if (r_fill_pos < PW'(SLOT_BYTES - 1)) begin
                        we         = 1'b1;
                        n_fill_pos = r_fill_pos + 1'b1;
                    end
                end else begin
                    we           = 1'b1;
                    n_fill_pos   = '0;
                    n_write_slot = next_slot(r_write_slot);
                    // full queue: drop the oldest message
                    if (next_slot(r_write_slot) == r_read_slot) begin
                        n_read_slot = next_slot(r_read_slot);
                        n_play_pos  = '0;
                    end
                end
            end else begin
                n_tick_phase = (phase_inc >= {1'b0, period}) ? 8'd0 : phase_inc[7:0];
                if (attempt && (r_read_slot != r_write_slot)) begin
                    if (char_a == 8'd0) begin
                        n_read_slot = next_slot(r_read_slot);
                        n_play_pos  = '0;
                    end else if (!i_cfg.sink_attached) begin
                        n_play_pos = r_play_pos + 1'b1;
                    end else if (i_item.sink_ready) begin
                        o_res.valid       = 1'b1;
                        o_res.played_char = char_a;
                        o_res.message_end = (char_b == 8'd0);
                        n_play_pos        = r_play_pos + 1'b1;
                    end
                end
            end
        end
    end

    // fetch the front characters for the state that the next item will see
    always_comb begin
        next_pos_wide = {1'b0, n_play_pos} + 1'b1;
        oob_a   = ({1'b0, n_play_pos} >= (PW + 1)'(SLOT_BYTES));
        oob_b   = (next_pos_wide >= (PW + 1)'(SLOT_BYTES));
        raddr_a = oob_a ? '0 : slot_addr(n_read_slot, n_play_pos);
        raddr_b = oob_b ? '0 : slot_addr(n_read_slot, next_pos_wide[PW-1:0]);
    end

    ptmq_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_we      (we),
        .i_waddr   (waddr),
        .i_wdata   (i_item.text_char),
        .i_raddr_a (raddr_a),
        .i_raddr_b (raddr_b),
        .o_rdata_a (q_a),
        .o_rdata_b (q_b)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_read_slot  <= '0;
            r_write_slot <= '0;
            r_play_pos   <= '0;
            r_fill_pos   <= '0;
            r_tick_phase <= '0;
            r_fwd_a      <= 1'b0;
            r_fwd_b      <= 1'b0;
            r_oob_a      <= 1'b0;
            r_oob_b      <= 1'b0;
        end else begin
            r_read_slot  <= n_read_slot;
            r_write_slot <= n_write_slot;
            r_play_pos   <= n_play_pos;
            r_fill_pos   <= n_fill_pos;
            r_tick_phase <= n_tick_phase;
            r_fwd_a      <= we && (waddr == raddr_a);
            r_fwd_b      <= we && (waddr == raddr_b);
            r_oob_a      <= oob_a;
            r_oob_b      <= oob_b;
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= i_item.text_char;
    end

endmodule
